[src/assert_macros.svh]
// Assertion macros for the checker file of the hash engine.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while the active-low reset is low.
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked property that is checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/mm3_pkg.sv]
// Types, constants and helper functions of the MurmurHash3 x86_32 engine.
// Has no dependencies; the engine, front, back and testbench import it.
`timescale 1ns / 1ps

package mm3_pkg;

    // Mixing constants of the x86_32 variant.
    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    // Register reset values.
    localparam logic [31:0] SEED_RESET = 32'h9747b28c;
    localparam logic        ZFE_RESET  = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_ZFE  = 1'b1;

    // Byte counts with a meaning of their own.
    localparam logic [2:0] NB_NONE = 3'd0;
    localparam logic [2:0] NB_ONE  = 3'd1;
    localparam logic [2:0] NB_TWO  = 3'd2;
    localparam logic [2:0] NB_FULL = 3'd4;

    // One classified word as it waits between the front and the back.
    typedef struct packed {
        logic [31:0] word;   // bytes above the count already cleared
        logic [2:0]  nb;     // 0 to 4 valid bytes
        logic        last;   // closes the message
    } mm3_entry_t;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [31:0] seed;
        logic        zero_for_empty;
    } mm3_cfg_t;

    // Sequencer of the back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } mm3_state_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

[src/murmur3_32_hash_engine.sv]
// MurmurHash3 x86_32 streaming engine, top level: configuration registers, front end
// with its queue and the back-end sequencer. Depends on mm3_pkg, mm3_front, mm3_back.
`timescale 1ns / 1ps

// Words of a message come in on the s_axis port as little-endian 32-bit words
// with tlast on the final one; one hash per message leaves on m_axis. The
// back end scrambles each word with two registered multiplies and mixes it
// in one step; the last word then gets two registered multiplies for the
// finalizer and the output step (an empty message under the zero rule goes
// straight to the output step). A queue of QUEUE_DEPTH words in front of the
// sequencer and the output register let either side stall on its own. The
// seed and the empty-message rule are to be written through the cfg port
// while no message is in flight; the block does not enforce it.
module murmur3_32_hash_engine import mm3_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word [31:0], valid_bytes [34:32], zeros
    input  logic        s_axis_tlast,
    // Hash results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hash [31:0]
);

    logic [31:0] seed_reg, seed_next;
    logic        zfe_reg, zfe_next;
    mm3_cfg_t    cfg;
    logic        q_valid;
    logic        q_pop;
    mm3_entry_t  q_entry;

    // Register writes.
    always_comb begin
        seed_next = seed_reg;
        zfe_next  = zfe_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_SEED: seed_next = cfg_wdata;
                REG_ZFE:  zfe_next  = cfg_wdata[0];
                default:  seed_next = seed_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
            zfe_reg  <= ZFE_RESET;
        end else begin
            seed_reg <= seed_next;
            zfe_reg  <= zfe_next;
        end
    end

    assign cfg = '{seed: seed_reg, zero_for_empty: zfe_reg};

    mm3_front #(
        .QDepth (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata[31:0]),
        .in_nb    (s_axis_tdata[34:32]),
        .in_last  (s_axis_tlast),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_entry  (q_entry)
    );

    mm3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

[src/mm3_front.sv]
// Front end of the hash engine: takes input transfers, classifies each word
// and holds it in a short queue for the back end. Depends on mm3_pkg.
`timescale 1ns / 1ps

module mm3_front import mm3_pkg::*; #(
    parameter int QDepth = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    input  logic [2:0]  in_nb,
    input  logic        in_last,
    input  logic        q_pop,
    output logic        q_valid,
    output mm3_entry_t  q_entry
);

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);
    localparam logic [PtrW-1:0] PTR_TOP = PtrW'(QDepth - 1);
    localparam logic [CntW-1:0] CNT_FULL = CntW'(QDepth);

    mm3_entry_t            entry_mem [QDepth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [2:0]            nb_eff;
    logic [31:0]           word_masked;
    logic                  push;
    logic                  pop;

    // Classify: a word that is not last always counts as four bytes, and
    // counts above four are read as four. Bytes above the count are cleared.
    always_comb begin
        if (!in_last || in_nb > NB_FULL) begin
            nb_eff = NB_FULL;
        end else begin
            nb_eff = in_nb;
        end
        case (nb_eff)
            NB_NONE: word_masked = 32'd0;
            NB_ONE:  word_masked = {24'd0, in_word[7:0]};
            NB_TWO:  word_masked = {16'd0, in_word[15:0]};
            NB_FULL: word_masked = in_word;
            default: word_masked = {8'd0, in_word[23:0]};
        endcase
    end

    assign in_ready = (cnt_reg != CNT_FULL);
    assign q_valid  = (cnt_reg != '0);
    assign q_entry  = entry_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_TOP) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_TOP) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= '{word: word_masked, nb: nb_eff, last: in_last};
        end
    end

endmodule

[src/mm3_back.sv]
// Back end of the hash engine: a sequencer that runs the body mix, tail mix
// and fmix32 finalizer over one queued word at a time. Depends on mm3_pkg.
`timescale 1ns / 1ps

module mm3_back import mm3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mm3_cfg_t    cfg,
    input  logic        q_valid,
    input  mm3_entry_t  q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_hash
);

    mm3_state_t  state_reg, state_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [2:0]  nb_reg, nb_next;
    logic        last_reg, last_next;
    logic        empty_reg, empty_next;
    logic        in_msg_reg, in_msg_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic        out_free;
    logic [31:0] mix_x;
    logic [31:0] mix_h;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MIX;
            ST_MIX: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (empty_reg && nb_reg == NB_NONE && cfg.zero_for_empty) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Queue pop.
    always_comb begin
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            default: q_pop = 1'b0;
        endcase
    end

    // Body or tail mix of the scrambled word into the running hash.
    always_comb begin
        mix_x = rotl13(h_reg ^ k_reg);
        case (nb_reg)
            NB_FULL: mix_h = {mix_x[29:0], 2'b00} + mix_x + MM_N;
            NB_NONE: mix_h = h_reg;
            default: mix_h = h_reg ^ k_reg;
        endcase
    end

    // Datapath, one step per state.
    always_comb begin
        k_next         = k_reg;
        h_next         = h_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        nb_next        = nb_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        in_msg_next    = in_msg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_hash_next  = out_hash_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    k_next     = q_entry.word;
                    nb_next    = q_entry.nb;
                    last_next  = q_entry.last;
                    empty_next = !in_msg_reg;
                    h_next     = in_msg_reg ? h_reg : cfg.seed;
                end
            end
            ST_MUL1: k_next = 32'(k_reg * MM_C1);
            ST_MUL2: k_next = 32'(rotl15(k_reg) * MM_C2);
            ST_MIX: begin
                if (!last_reg) begin
                    h_next      = mix_h;
                    cnt_next    = cnt_reg + 32'd4;
                    in_msg_next = 1'b1;
                end else begin
                    cnt_next    = '0;
                    in_msg_next = 1'b0;
                    if (empty_reg && nb_reg == NB_NONE && cfg.zero_for_empty) begin
                        acc_next = '0;
                    end else begin
                        acc_next = mix_h ^ (cnt_reg + {29'd0, nb_reg});
                    end
                end
            end
            ST_FIN1: acc_next = 32'((acc_reg ^ {16'd0, acc_reg[31:16]}) * MM_F1);
            ST_FIN2: acc_next = 32'((acc_reg ^ {13'd0, acc_reg[31:13]}) * MM_F2);
            ST_EMIT: begin
                // A zero accumulator finalizes to zero, which covers the empty case.
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = acc_reg ^ {16'd0, acc_reg[31:16]};
                end
            end
            default: begin
                k_next = k_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_msg_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        h_reg        <= h_next;
        acc_reg      <= acc_next;
        nb_reg       <= nb_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

endmodule

[src/mm3_checker.sv]
// Port-level checks of the hash engine, attached to the top level by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic       s_last_xfer;
    logic       m_xfer;
    logic [7:0] open_reg, open_next;

    assign s_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign m_xfer      = m_axis_tvalid && m_axis_tready;

    // Messages closed at the input whose hash has not yet been taken.
    always_comb begin
        open_next = open_reg;
        if (s_last_xfer && !m_xfer) begin
            open_next = open_reg + 8'd1;
        end else if (m_xfer && !s_last_xfer) begin
            open_next = open_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    `ASSERT_CLK_RST(a_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result withdrawn before its transfer")
    `ASSERT_CLK_RST(a_hold_data, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    `ASSERT_CLK(a_reset_quiet, aclk, !aresetn |=> !m_axis_tvalid, "result offered straight after reset")
    `ASSERT_CLK_RST(a_no_invented, aclk, aresetn, m_axis_tvalid |-> open_reg != 8'd0, "result without a closed message")

endmodule

bind murmur3_32_hash_engine mm3_checker u_mm3_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/testbench.sv]
// Self-checking testbench for murmur3_32_hash_engine: streams messages of words,
// predicts each MurmurHash3 x86_32 value and compares it with the hash port.
// Depends on mm3_pkg and the engine RTL only.
`timescale 1ns / 1ps

import mm3_pkg::*;

// Predicts the hash of each message and keeps the hashes still due.
class murmur_tracker;
    localparam logic [31:0] K_C1 = 32'hcc9e2d51;
    localparam logic [31:0] K_C2 = 32'h1b873593;
    localparam logic [31:0] K_N  = 32'he6546b64;
    localparam logic [31:0] K_F1 = 32'h85ebca6b;
    localparam logic [31:0] K_F2 = 32'hc2b2ae35;

    logic [31:0] seed_reg;
    logic        zero_empty_reg;
    logic [31:0] running_hash;
    logic [31:0] byte_count;
    bit          in_message;
    logic [31:0] expected_hashes[$];
    int          errors;

    function new();
        seed_reg       = 32'h9747b28c;
        zero_empty_reg = 1'b1;
        running_hash   = seed_reg;
        byte_count     = '0;
        in_message     = 1'b0;
        errors         = 0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function logic [31:0] scramble(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_C1;
        t = rotl(t, 15);
        t = t * K_C2;
        return t;
    endfunction

    function logic [31:0] body_mix(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = h ^ scramble(k);
        t = rotl(t, 13);
        t = t * 32'd5 + K_N;
        return t;
    endfunction

    function logic [31:0] fmix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * K_F1;
        t = t ^ (t >> 13);
        t = t * K_F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    function void set_reg(input logic addr, input logic [31:0] value);
        if (addr == REG_SEED) begin
            seed_reg = value;
        end else begin
            zero_empty_reg = value[0];
        end
    endfunction

    // Notes one accepted word; a closing word queues the hash of its message.
    function void take_word(input logic [31:0] word, input logic [2:0] nb, input logic last);
        logic [31:0] h;
        logic [31:0] mask;
        logic [2:0]  n;
        bit          was_empty;
        h = in_message ? running_hash : seed_reg;
        was_empty = !in_message;
        if (!last) begin
            // The count of a word that is not last is ignored: four bytes.
            running_hash = body_mix(h, word);
            byte_count = byte_count + 32'd4;
            in_message = 1'b1;
            return;
        end
        n = (nb > NB_FULL) ? NB_FULL : nb;
        if (n == NB_FULL) begin
            h = body_mix(h, word);
        end else if (n != NB_NONE) begin
            mask = 32'hffffffff >> (8 * (4 - n));
            h = h ^ scramble(word & mask);
        end
        if (was_empty && n == NB_NONE && zero_empty_reg) begin
            expected_hashes.push_back(32'd0);
        end else begin
            expected_hashes.push_back(fmix(h ^ (byte_count + n)));
        end
        running_hash = seed_reg;
        byte_count = '0;
        in_message = 1'b0;
    endfunction

    // Compares one hash transfer with the oldest hash still due.
    function void check_hash(input logic [31:0] actual);
        logic [31:0] due;
        if (expected_hashes.size() == 0) begin
            $display("%0t: hash %08h arrived with none expected", $time, actual);
            errors++;
        end else begin
            due = expected_hashes.pop_front();
            if (actual !== due) begin
                $display("%0t: hash mismatch, expected %08h, actual %08h",
                         $time, due, actual);
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int END_CYCLES     = 40;
    localparam int WORDS_PER_RUN  = 145;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_addr      = REG_SEED;
    logic [31:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    murmur_tracker tracker = new();
    int send_idle_pct = 10;
    int recv_idle_pct = 77;
    int words_sent = 0;
    int quiet_cycles = 0;

    murmur3_32_hash_engine uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock.
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Every transfer on either side is noted at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.take_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_hash(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // The result side stalls at random.
    always @(negedge aclk) begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends a run that has stopped making progress.
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL murmur3_32_hash_engine");
        $finish;
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(19))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    // Offers one word after a random gap and holds it until the transfer.
    task automatic send_word(input logic [31:0] word, input logic [2:0] nb, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, nb, word};
        s_axis_tlast  = last;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Holds the input back until every hash due has come and the engine is quiet.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (tracker.expected_hashes.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(posedge aclk);
        tracker.set_reg(addr, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // A message of mostly short length, now and then a long one.
    task automatic send_random_message();
        int          body;
        logic [2:0]  nb;
        body = ($urandom_range(99) < 5) ? $urandom_range(40, 8) : $urandom_range(6);
        for (int i = 0; i < body; i++) begin
            send_word(random_word(), 3'($urandom_range(7)), 1'b0);
        end
        nb = ($urandom_range(99) < 15) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        send_word(random_word(), nb, 1'b1);
    endtask

    initial begin
        logic [31:0] seed_value;
        logic [31:0] zfe_value;
        int          goal;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset configuration first.
        // Empty message: bytes above a zero count are ignored, hash is zero.
        send_word(32'hffffffff, NB_NONE, 1'b1);
        // Single-word messages with every tail length.
        send_word(32'hffffffff, NB_ONE, 1'b1);
        send_word(32'hffffffff, NB_TWO, 1'b1);
        send_word(32'h80808080, 3'd3, 1'b1);
        send_word(32'h00000000, NB_FULL, 1'b1);
        // A count above four on the last word is taken as four.
        send_word(32'hffffffff, 3'd7, 1'b1);
        // A short count on a word that is not last still counts four bytes.
        send_word(32'hffffffff, NB_NONE, 1'b0);
        send_word(32'h12345678, 3'd5, 1'b1);
        send_word(32'h00000000, 3'd3, 1'b0);
        send_word(32'hdeadbeef, NB_NONE, 1'b1);
        send_word(32'h89abcdef, 3'd6, 1'b0);
        send_word(32'h76543210, 3'd3, 1'b1);

        // An empty message with the zero rule off, then the seed extremes.
        drain();
        write_reg(REG_ZFE, 32'h0);
        write_reg(REG_SEED, 32'h0);
        send_word(32'h0, NB_NONE, 1'b1);
        send_word(32'hffffffff, NB_FULL, 1'b1);
        drain();
        write_reg(REG_SEED, 32'hffffffff);
        send_word(32'h0, NB_NONE, 1'b1);
        send_word(32'hffffffff, NB_FULL, 1'b0);
        send_word(32'hffffffff, NB_ONE, 1'b1);

        // Random messages in three idling phases, each over several settings.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int run = 0; run < 4; run++) begin
                drain();
                case (run)
                    0:       seed_value = 32'h00000000;
                    1:       seed_value = 32'hffffffff;
                    default: seed_value = $urandom();
                endcase
                // Upper bits of the flag write carry noise and must be ignored.
                zfe_value = $urandom();
                zfe_value[0] = run[0];
                write_reg(REG_SEED, seed_value);
                write_reg(REG_ZFE, zfe_value);
                goal = words_sent + WORDS_PER_RUN;
                while (words_sent < goal) begin
                    send_random_message();
                    if ($urandom_range(99) < 3) begin
                        drain();
                    end
                end
            end
        end

        // Let every hash due arrive, then watch a little longer for strays.
        s_axis_tvalid = 1'b0;
        while (tracker.expected_hashes.size() != 0) @(negedge aclk);
        repeat (END_CYCLES) @(negedge aclk);
        if (tracker.errors == 0 && tracker.expected_hashes.size() == 0) begin
            $display("PASS murmur3_32_hash_engine");
        end else begin
            $display("FAIL murmur3_32_hash_engine");
        end
        $finish;
    end
endmodule
